// ===== rtl/i2c_register_access_master_defines.svh =====
`ifndef I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset
`define I2CRAM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2cram check failed");

// Next-cycle implication, checked on every clock outside reset
`define I2CRAM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2cram check failed");

`endif

// ===== rtl/i2cram_pkg.sv =====
package i2cram_pkg;

	// Bus sequencer phase codes
	localparam logic [4:0] PH_IDLE = 5'd0;
	localparam logic [4:0] PH_ST0  = 5'd1;
	localparam logic [4:0] PH_ST1  = 5'd2;
	localparam logic [4:0] PH_ST2  = 5'd3;
	localparam logic [4:0] PH_ST3  = 5'd4;
	localparam logic [4:0] PH_TX0  = 5'd5;
	localparam logic [4:0] PH_TX1  = 5'd6;
	localparam logic [4:0] PH_TX2  = 5'd7;
	localparam logic [4:0] PH_TX3  = 5'd8;
	localparam logic [4:0] PH_AK0  = 5'd9;
	localparam logic [4:0] PH_AKP  = 5'd10;
	localparam logic [4:0] PH_AK2  = 5'd11;
	localparam logic [4:0] PH_RX0  = 5'd12;
	localparam logic [4:0] PH_RX1  = 5'd13;
	localparam logic [4:0] PH_RX2  = 5'd14;
	localparam logic [4:0] PH_RX3  = 5'd15;
	localparam logic [4:0] PH_NK0  = 5'd16;
	localparam logic [4:0] PH_NK1  = 5'd17;
	localparam logic [4:0] PH_NK2  = 5'd18;
	localparam logic [4:0] PH_NK3  = 5'd19;
	localparam logic [4:0] PH_SP0  = 5'd20;
	localparam logic [4:0] PH_SP1  = 5'd21;
	localparam logic [4:0] PH_SP2  = 5'd22;
	localparam logic [4:0] PH_GD   = 5'd23;

	// Command codes
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// Byte steps within one attempt
	localparam logic [1:0] STEP_DEV = 2'd0;
	localparam logic [1:0] STEP_REG = 2'd1;
	localparam logic [1:0] STEP_LAST = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GUARD_TICKS = 3'd4;

	// Configuration reset values
	localparam logic [6:0]  RST_DEV_ADDR    = 7'h10;
	localparam logic [15:0] RST_PHASE_TICKS = 16'd100;
	localparam logic [11:0] RST_ACK_TIMEOUT = 12'd2000;
	localparam logic [2:0]  RST_ATTEMPT_LIM = 3'd3;
	localparam logic [15:0] RST_GUARD_TICKS = 16'd10000;

	typedef struct packed {
		logic [6:0]  device_address;
		logic [15:0] phase_ticks;
		logic [11:0] ack_timeout_ticks;
		logic [2:0]  attempt_limit;
		logic [15:0] write_guard_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic       success;
		logic [7:0] read_data;
	} result_t;

	typedef struct packed {
		logic [4:0]  bus_phase;
		logic [3:0]  bit_position;
		logic [7:0]  shift_byte;
		logic [15:0] tick_count;
		logic [11:0] ack_wait_count;
		logic [2:0]  attempts_used;
		logic        is_read_op;
		logic [7:0]  latched_register;
		logic [7:0]  latched_data;
		logic [7:0]  received_byte;
		logic [1:0]  byte_step;
		logic        attempt_good;
	} seq_t;

endpackage

// ===== rtl/i2cram_in_if.sv =====
interface i2cram_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] reg_addr;
	logic [7:0] write_data;
	logic       sda_in;

	modport source (output valid, func, reg_addr, write_data, sda_in, input ready);
	modport sink (input valid, func, reg_addr, write_data, sda_in, output ready);
endinterface

// ===== rtl/i2cram_out_if.sv =====
interface i2cram_out_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_release;
	logic       busy_res;
	logic       done_res;
	logic       success;
	logic [7:0] read_data;

	modport source (output valid, scl_level, sda_release, busy_res, done_res, success,
		read_data, input ready);
	modport sink (input valid, scl_level, sda_release, busy_res, done_res, success,
		read_data, output ready);
endinterface

// ===== rtl/i2cram_cfg.sv =====
module i2cram_cfg import i2cram_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register file, writes past the last index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address    <= RST_DEV_ADDR;
			cfg_q.phase_ticks       <= RST_PHASE_TICKS;
			cfg_q.ack_timeout_ticks <= RST_ACK_TIMEOUT;
			cfg_q.attempt_limit     <= RST_ATTEMPT_LIM;
			cfg_q.write_guard_ticks <= RST_GUARD_TICKS;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				CFG_DEV_ADDR:    cfg_q.device_address    <= cfg_wdata[6:0];
				CFG_PHASE_TICKS: cfg_q.phase_ticks       <= cfg_wdata[15:0];
				CFG_ACK_TIMEOUT: cfg_q.ack_timeout_ticks <= cfg_wdata[11:0];
				CFG_ATTEMPT_LIM: cfg_q.attempt_limit     <= cfg_wdata[2:0];
				CFG_GUARD_TICKS: cfg_q.write_guard_ticks <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/i2cram_step.sv =====
module i2cram_step import i2cram_pkg::*; (
	input  seq_t    cur,
	input  cfg_t    cfg,
	input  item_t   item,
	output seq_t    nxt,
	output result_t res
);

	logic [15:0] quarter;
	logic [11:0] ack_lim;
	logic [2:0]  att_lim;
	logic [15:0] tick_inc;
	logic [11:0] ackw_inc;
	logic [3:0]  bit_inc;
	logic [2:0]  att_inc;
	logic        do_decide;
	logic        fin;
	logic        fin_ok;
	logic [4:0]  ph;
	logic [4:0]  off_st;
	logic [4:0]  off_tx;
	logic [4:0]  off_rx;
	logic [4:0]  off_sp;

	// Zero settings behave as one
	assign quarter = (cfg.phase_ticks == '0) ? 16'd1 : cfg.phase_ticks;
	assign ack_lim = (cfg.ack_timeout_ticks == '0) ? 12'd1 : cfg.ack_timeout_ticks;
	assign att_lim = (cfg.attempt_limit == '0) ? 3'd1 : cfg.attempt_limit;

	assign tick_inc = cur.tick_count + 16'd1;
	assign ackw_inc = cur.ack_wait_count + 12'd1;
	assign bit_inc  = cur.bit_position + 4'd1;

	// Next sequencer state
	always_comb begin
		nxt       = cur;
		do_decide = 1'b0;
		fin       = 1'b0;
		fin_ok    = 1'b0;
		att_inc   = cur.attempts_used + 3'd1;

		if (cur.bus_phase == PH_IDLE || cur.bus_phase > PH_GD) begin
			nxt.bus_phase = PH_IDLE;
			if (item.func == FUNC_WRITE || item.func == FUNC_READ) begin
				nxt.latched_register = item.reg_addr;
				nxt.latched_data     = item.write_data;
				nxt.is_read_op       = (item.func == FUNC_READ);
				nxt.attempts_used    = '0;
				nxt.bus_phase        = PH_ST0;
				nxt.tick_count       = '0;
				nxt.bit_position     = '0;
				nxt.byte_step        = STEP_DEV;
				nxt.attempt_good     = 1'b1;
			end
		end else if (cur.bus_phase == PH_AKP) begin
			// acknowledge poll, one tick at a time
			if (!item.sda_in) begin
				nxt.bus_phase  = PH_AK2;
				nxt.tick_count = '0;
			end else begin
				nxt.ack_wait_count = ackw_inc;
				if (ackw_inc >= ack_lim) begin
					nxt.attempt_good = 1'b0;
					nxt.bus_phase    = PH_AK2;
					nxt.tick_count   = '0;
				end
			end
		end else if (cur.bus_phase == PH_GD) begin
			nxt.tick_count = tick_inc;
			if (tick_inc >= cfg.write_guard_ticks) begin
				do_decide = 1'b1;
			end
		end else if (tick_inc < quarter) begin
			nxt.tick_count = tick_inc;
		end else begin
			// end of a quarter
			nxt.tick_count = '0;
			unique case (cur.bus_phase)
				PH_ST0, PH_ST1, PH_ST2, PH_TX0, PH_TX1, PH_TX2, PH_RX0, PH_RX2,
				PH_NK0, PH_NK1, PH_NK2, PH_SP0, PH_SP1: begin
					nxt.bus_phase = cur.bus_phase + 5'd1;
				end
				PH_RX1: begin
					nxt.shift_byte = {cur.shift_byte[6:0], item.sda_in};
					nxt.bus_phase  = PH_RX2;
				end
				PH_ST3: begin
					nxt.shift_byte   = {cfg.device_address, cur.byte_step == STEP_LAST};
					nxt.bit_position = '0;
					nxt.bus_phase    = PH_TX0;
				end
				PH_TX3: begin
					nxt.shift_byte   = {cur.shift_byte[6:0], 1'b0};
					nxt.bit_position = bit_inc;
					nxt.bus_phase    = (bit_inc >= 4'd8) ? PH_AK0 : PH_TX0;
				end
				PH_AK0: begin
					nxt.ack_wait_count = '0;
					nxt.bus_phase      = PH_AKP;
				end
				PH_AK2: begin
					if (!cur.attempt_good) begin
						nxt.bus_phase = PH_SP0;
					end else if (cur.byte_step == STEP_DEV) begin
						nxt.byte_step    = STEP_REG;
						nxt.shift_byte   = cur.latched_register;
						nxt.bit_position = '0;
						nxt.bus_phase    = PH_TX0;
					end else if (cur.byte_step == STEP_REG) begin
						nxt.byte_step = STEP_LAST;
						if (cur.is_read_op) begin
							nxt.bus_phase = PH_ST0;
						end else begin
							nxt.shift_byte   = cur.latched_data;
							nxt.bit_position = '0;
							nxt.bus_phase    = PH_TX0;
						end
					end else if (cur.is_read_op) begin
						nxt.shift_byte   = '0;
						nxt.bit_position = '0;
						nxt.bus_phase    = PH_RX0;
					end else begin
						nxt.bus_phase = PH_SP0;
					end
				end
				PH_RX3: begin
					nxt.bit_position = bit_inc;
					nxt.bus_phase    = (bit_inc >= 4'd8) ? PH_NK0 : PH_RX0;
				end
				PH_NK3: begin
					nxt.bus_phase = PH_SP0;
				end
				PH_SP2: begin
					if (cur.is_read_op) begin
						do_decide = 1'b1;
					end else begin
						nxt.bus_phase = PH_GD;
						if (cfg.write_guard_ticks == '0) begin
							do_decide = 1'b1;
						end
					end
				end
				default: begin
					nxt.bus_phase = PH_IDLE;
				end
			endcase
		end

		// End of attempt: finish or retry
		if (do_decide) begin
			if (nxt.attempt_good) begin
				if (nxt.is_read_op) begin
					nxt.received_byte = nxt.shift_byte;
				end
				nxt.bus_phase  = PH_IDLE;
				nxt.tick_count = '0;
				fin            = 1'b1;
				fin_ok         = 1'b1;
			end else begin
				nxt.attempts_used = att_inc;
				if (att_inc >= att_lim) begin
					nxt.bus_phase  = PH_IDLE;
					nxt.tick_count = '0;
					fin            = 1'b1;
				end else begin
					nxt.bus_phase    = PH_ST0;
					nxt.tick_count   = '0;
					nxt.bit_position = '0;
					nxt.byte_step    = STEP_DEV;
					nxt.attempt_good = 1'b1;
				end
			end
		end
	end

	// Line levels from the updated phase
	assign ph     = nxt.bus_phase;
	assign off_st = ph - PH_ST0;
	assign off_tx = ph - PH_TX0;
	assign off_rx = ph - PH_RX0;
	assign off_sp = ph - PH_SP0;

	always_comb begin
		res.scl_level   = 1'b1;
		res.sda_release = 1'b1;
		if (ph >= PH_ST0 && ph <= PH_ST3) begin
			res.scl_level   = (off_st[1:0] == 2'd1 || off_st[1:0] == 2'd2);
			res.sda_release = (off_st[1:0] <= 2'd1);
		end else if (ph >= PH_TX0 && ph <= PH_TX3) begin
			res.scl_level   = (off_tx[1:0] == 2'd1 || off_tx[1:0] == 2'd2);
			res.sda_release = nxt.shift_byte[7];
		end else if (ph == PH_AK0 || ph == PH_AK2) begin
			res.scl_level = 1'b0;
		end else if (ph >= PH_RX0 && ph <= PH_NK3) begin
			res.scl_level = (off_rx[1:0] == 2'd1 || off_rx[1:0] == 2'd2);
		end else if (ph >= PH_SP0 && ph <= PH_SP2) begin
			res.scl_level   = (off_sp[1:0] >= 2'd1);
			res.sda_release = (off_sp[1:0] == 2'd2);
		end
		res.busy_res  = (ph != PH_IDLE);
		res.done_res  = fin;
		res.success   = fin && fin_ok;
		res.read_data = nxt.received_byte;
	end

endmodule

// ===== rtl/i2c_register_access_master.sv =====
// A beat accepted into the input register passes through the sequencer step,
// and its result beat is offered from the result register.
// Throughput: one beat per cycle; the sequencer step sits between an input
// register and a result register, and stalls only while the result is held.
// Reset (arst_n low): sequencer idle with all counters and bytes cleared,
// configuration back to its defaults, no beat held on either side.
module i2c_register_access_master import i2cram_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	i2cram_in_if.sink             cmd,
	i2cram_out_if.source          res,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg;
	seq_t    seq_q;
	seq_t    seq_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_nxt;
	result_t res_q;
	logic    res_valid_q;
	logic    step_go;

	i2cram_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	i2cram_step u_step (
		.cur  (seq_q),
		.cfg  (cfg),
		.item (item_s1),
		.nxt  (seq_nxt),
		.res  (res_nxt)
	);

	// Step fires when an input beat is held and the result slot frees up
	assign step_go   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || step_go;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (step_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.func       <= cmd.func;
			item_s1.reg_addr   <= cmd.reg_addr;
			item_s1.write_data <= cmd.write_data;
			item_s1.sda_in     <= cmd.sda_in;
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (step_go) begin
			seq_q <= seq_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step_go) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			res_q <= res_nxt;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.scl_level   = res_q.scl_level;
	assign res.sda_release = res_q.sda_release;
	assign res.busy_res    = res_q.busy_res;
	assign res.done_res    = res_q.done_res;
	assign res.success     = res_q.success;
	assign res.read_data   = res_q.read_data;

endmodule

// ===== rtl/i2cram_chk.sv =====
`include "i2c_register_access_master_defines.svh"

module i2cram_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       scl_level,
	input logic       sda_release,
	input logic       busy_res,
	input logic       done_res,
	input logic       success,
	input logic [7:0] read_data
);

	// A finished command leaves the bus idle
	`I2CRAM_ASSERT_NOW(a_done_idle, res_valid && done_res, !busy_res)

	// Success is only reported on the finishing beat
	`I2CRAM_ASSERT_NOW(a_success_done, res_valid && success, done_res)

	// Idle bus has both lines released
	`I2CRAM_ASSERT_NOW(a_idle_lines, res_valid && !busy_res, scl_level && sda_release)

	// A stalled result beat holds
	`I2CRAM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
		res_valid && $stable({scl_level, sda_release, busy_res, done_res, success, read_data}))

endmodule

bind i2c_register_access_master i2cram_chk u_i2cram_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.scl_level   (res.scl_level),
	.sda_release (res.sda_release),
	.busy_res    (res.busy_res),
	.done_res    (res.done_res),
	.success     (res.success),
	.read_data   (res.read_data)
);
